FILE: hdl/separable_ar1_field_filter_assert.svh
// Assertion macros for the separable AR(1) field filter.
// Each check is clocked on clk and switched off while rst is high.
`ifndef SEPARABLE_AR1_FIELD_FILTER_ASSERT_SVH
`define SEPARABLE_AR1_FIELD_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SAFF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("saff assertion failed");
`define SAFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("saff assertion failed");
`else
`define SAFF_ASSERT_SAME(lbl, ante, cons)
`define SAFF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/saff_pkg.sv
package saff_pkg;

  localparam int MAX_ROW_LEN = 1024;
  localparam int MAX_PLANE   = 16384;
  localparam int ROWS_LIMIT  = 16384;
  localparam int NUM_AXES    = 3;

  localparam int COL_W      = $clog2(MAX_ROW_LEN);   // column index
  localparam int LEN_W      = 11;                    // row_length register
  localparam int ROW_W      = $clog2(ROWS_LIMIT);    // row index
  localparam int RPP_W      = 15;                    // rows_per_plane register
  localparam int PLANE_AW   = $clog2(MAX_PLANE);     // plane store address
  localparam int POS_W      = ROW_W + LEN_W + 1;     // row * len + col
  localparam int CFG_DATA_W = 17;

  typedef enum logic [2:0] {
    CFG_ROW_LENGTH     = 3'd0,
    CFG_ROWS_PER_PLANE = 3'd1,
    CFG_RHO_AXIS1      = 3'd2,
    CFG_RHO_AXIS2      = 3'd3,
    CFG_RHO_AXIS3      = 3'd4,
    CFG_GAIN_AXIS1     = 3'd5,
    CFG_GAIN_AXIS2     = 3'd6,
    CFG_GAIN_AXIS3     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] noise_sample;
    logic               start_of_field;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] filtered_value;
    logic               saturated;
    logic               plane_overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               clipped;
  } stage_res_t;

endpackage

FILE: hdl/separable_ar1_field_filter.sv
//  channel | signals                              | transfer when
//  --------+--------------------------------------+---------------------------
//  input   | in_valid, in_ready, in_item          | in_valid && in_ready
//  output  | out_valid, out_ready, out_item       | out_valid && out_ready
//  config  | cfg_write, cfg_index, cfg_data       | cfg_write (no handshake)
//
//  Samples are taken one at a time: the accept state, then a launch and a
//  result state per axis on the shared multiply unit (product register,
//  then sum/round/clip). The result lands in an output register; the next
//  sample is taken while it waits. If that register is still full at the
//  end of axis three, the block holds there until the output side drains it.
//  Synchronous reset clears control state and config; the line and plane
//  stores need no clearing.
`include "separable_ar1_field_filter_assert.svh"

module separable_ar1_field_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  saff_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output saff_pkg::out_item_t                 out_item,
  input  logic                                cfg_write,
  input  logic [2:0]                          cfg_index,
  input  logic [saff_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AX1,    // launch axis one, compute plane position
    S_AX1W,   // axis one result
    S_AX2,    // launch axis two with line store data
    S_AX2W,   // axis two result, line store write
    S_AX3,    // launch axis three with plane store data
    S_AX3W    // axis three result, plane store write, emit
  } state_t;

  state_t state;

  // configuration
  logic        [saff_pkg::LEN_W-1:0] row_length;
  logic        [saff_pkg::RPP_W-1:0] rows_per_plane;
  logic signed [16:0]                rho_axis1, rho_axis2, rho_axis3;
  logic        [15:0]                gain_axis1, gain_axis2, gain_axis3;

  // position state
  logic        [saff_pkg::COL_W-1:0] col;
  logic        [saff_pkg::ROW_W-1:0] row;
  logic                              in_first_plane;
  logic signed [15:0]                axis1_previous;

  // per-sample working registers
  logic signed [15:0]                y;
  logic                              sat;
  logic        [saff_pkg::POS_W-1:0] pos;
  logic                              ovf;

  // effective sizes
  logic        [saff_pkg::LEN_W-1:0] len;
  logic        [saff_pkg::RPP_W-1:0] rpp;

  // stores (contents undefined until written)
  logic signed [15:0] line_store  [saff_pkg::MAX_ROW_LEN];
  logic signed [15:0] plane_store [saff_pkg::MAX_PLANE];
  logic signed [15:0] line_rd;
  logic signed [15:0] plane_rd;
  logic               line_we;
  logic               plane_we;
  logic [saff_pkg::PLANE_AW-1:0] plane_addr;

  // shared stage unit
  logic signed [16:0]   st_rho;
  logic        [15:0]   st_gain;
  logic signed [15:0]   st_prev;
  saff_pkg::stage_res_t st_res;

  logic               apply;
  logic signed [15:0] y_sel;
  logic               sat_sel;
  logic               out_free;
  logic [saff_pkg::LEN_W-1:0] col_inc;
  logic [saff_pkg::RPP_W-1:0] row_inc;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // zero acts as one, oversize clamps to the store limits
  always_comb begin
    if (row_length == '0) begin
      len = saff_pkg::LEN_W'(1);
    end else if (row_length > saff_pkg::LEN_W'(saff_pkg::MAX_ROW_LEN)) begin
      len = saff_pkg::LEN_W'(saff_pkg::MAX_ROW_LEN);
    end else begin
      len = row_length;
    end
    if (rows_per_plane == '0) begin
      rpp = saff_pkg::RPP_W'(1);
    end else if (rows_per_plane > saff_pkg::RPP_W'(saff_pkg::ROWS_LIMIT)) begin
      rpp = saff_pkg::RPP_W'(saff_pkg::ROWS_LIMIT);
    end else begin
      rpp = rows_per_plane;
    end
  end

  // operand select for the shared stage
  always_comb begin
    case (state)
      S_AX1: begin
        st_rho  = rho_axis1;
        st_gain = gain_axis1;
        st_prev = axis1_previous;
      end
      S_AX2: begin
        st_rho  = rho_axis2;
        st_gain = gain_axis2;
        st_prev = line_rd;
      end
      // kept through an output stall so the product registers hold
      S_AX3, S_AX3W: begin
        st_rho  = rho_axis3;
        st_gain = gain_axis3;
        st_prev = plane_rd;
      end
      default: begin
        st_rho  = '0;
        st_gain = '0;
        st_prev = '0;
      end
    endcase
  end

  saff_stage u_stage (
    .clk  (clk),
    .rho  (st_rho),
    .gain (st_gain),
    .prev (st_prev),
    .x    (y),
    .res  (st_res)
  );

  // first element on an axis passes through; unused axes bypass
  always_comb begin
    case (state)
      S_AX1W:  apply = (col != '0);
      S_AX2W:  apply = (saff_pkg::NUM_AXES >= 2) && (row != '0);
      S_AX3W:  apply = (saff_pkg::NUM_AXES >= 3) && !in_first_plane && !ovf;
      default: apply = 1'b0;
    endcase
    y_sel   = apply ? st_res.value : y;
    sat_sel = sat || (apply && st_res.clipped);
  end

  assign line_we    = (state == S_AX2W) && (saff_pkg::NUM_AXES >= 2);
  assign plane_we   = (state == S_AX3W) && out_free && !ovf;
  assign plane_addr = pos[saff_pkg::PLANE_AW-1:0];
  assign col_inc    = saff_pkg::LEN_W'(col) + saff_pkg::LEN_W'(1);
  assign row_inc    = saff_pkg::RPP_W'(row) + saff_pkg::RPP_W'(1);

  // line store: registered read at the current column
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_store[col] <= y_sel;
    end
    line_rd <= line_store[col];
  end

  // plane store: registered read at the plane position
  always_ff @(posedge clk) begin
    if (plane_we) begin
      plane_store[plane_addr] <= y_sel;
    end
    plane_rd <= plane_store[plane_addr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= saff_pkg::LEN_W'(1);
      rows_per_plane <= saff_pkg::RPP_W'(1);
      rho_axis1      <= '0;
      rho_axis2      <= '0;
      rho_axis3      <= '0;
      gain_axis1     <= 16'd32768;
      gain_axis2     <= 16'd32768;
      gain_axis3     <= 16'd32768;
    end else if (cfg_write) begin
      case (saff_pkg::cfg_idx_t'(cfg_index))
        saff_pkg::CFG_ROW_LENGTH:     row_length     <= cfg_data[saff_pkg::LEN_W-1:0];
        saff_pkg::CFG_ROWS_PER_PLANE: rows_per_plane <= cfg_data[saff_pkg::RPP_W-1:0];
        saff_pkg::CFG_RHO_AXIS1:      rho_axis1      <= cfg_data;
        saff_pkg::CFG_RHO_AXIS2:      rho_axis2      <= cfg_data;
        saff_pkg::CFG_RHO_AXIS3:      rho_axis3      <= cfg_data;
        saff_pkg::CFG_GAIN_AXIS1:     gain_axis1     <= cfg_data[15:0];
        saff_pkg::CFG_GAIN_AXIS2:     gain_axis2     <= cfg_data[15:0];
        saff_pkg::CFG_GAIN_AXIS3:     gain_axis3     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, position counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      col            <= '0;
      row            <= '0;
      in_first_plane <= 1'b1;
      axis1_previous <= '0;
    end else begin
      // S_AX3W refills the output register itself when it drains
      if (out_valid && out_ready && (state != S_AX3W)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            y   <= in_item.noise_sample;
            sat <= 1'b0;
            if (in_item.start_of_field) begin
              col            <= '0;
              row            <= '0;
              in_first_plane <= 1'b1;
            end
            state <= S_AX1;
          end
        end
        S_AX1: begin
          pos   <= saff_pkg::POS_W'(row) * saff_pkg::POS_W'(len) +
                   saff_pkg::POS_W'(col);
          state <= S_AX1W;
        end
        S_AX1W: begin
          y              <= y_sel;
          sat            <= sat_sel;
          axis1_previous <= y_sel;
          ovf            <= (saff_pkg::NUM_AXES >= 3) &&
                            (pos >= saff_pkg::POS_W'(saff_pkg::MAX_PLANE));
          state          <= S_AX2;
        end
        S_AX2: begin
          state <= S_AX2W;
        end
        S_AX2W: begin
          y     <= y_sel;
          sat   <= sat_sel;
          state <= S_AX3;
        end
        S_AX3: begin
          state <= S_AX3W;
        end
        S_AX3W: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_item.filtered_value  <= y_sel;
            out_item.saturated       <= sat_sel;
            out_item.plane_overflow  <= ovf;
            // raster advance against the current sizes
            if (col_inc >= len) begin
              col <= '0;
              if (row_inc >= rpp) begin
                row            <= '0;
                in_first_plane <= 1'b0;
              end else begin
                row <= row_inc[saff_pkg::ROW_W-1:0];
              end
            end else begin
              col <= col_inc[saff_pkg::COL_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted sample keeps the input closed for the next cycle
  `SAFF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a finished result waits in the last step while the output is full
  `SAFF_ASSERT_NEXT(a_hold_on_stall, state == S_AX3W && out_valid && !out_ready,
                    state == S_AX3W)
  // results are only produced at the end of axis three
  `SAFF_ASSERT_SAME(a_result_source, $rose(out_valid), $past(state == S_AX3W))

endmodule

FILE: hdl/saff_stage.sv
// One AR(1) stage: y = rho*prev + gain*x, Q6.27 -> Q4.12, round half up,
// saturate. Products registered, sum/round/clip in the following cycle.
module saff_stage (
  input  logic                      clk,
  input  logic signed [16:0]        rho,
  input  logic        [15:0]        gain,
  input  logic signed [15:0]        prev,
  input  logic signed [15:0]        x,
  output saff_pkg::stage_res_t      res
);

  logic signed [32:0] prod_rho;
  logic signed [32:0] prod_gain;
  logic signed [34:0] sum;
  logic signed [19:0] q;

  always_ff @(posedge clk) begin
    prod_rho  <= rho * prev;
    prod_gain <= $signed({1'b0, gain}) * x;
  end

  always_comb begin
    sum = 35'(prod_rho) + 35'(prod_gain) + 35'sd16384;
    q   = sum[34:15];
    if (q > 20'sd32767) begin
      res.value   = 16'sh7fff;
      res.clipped = 1'b1;
    end else if (q < -20'sd32768) begin
      res.value   = 16'sh8000;
      res.clipped = 1'b1;
    end else begin
      res.value   = q[15:0];
      res.clipped = 1'b0;
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import saff_pkg::*;

  // Timeout and idling limits
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_MAX     = 12;
  localparam int RANDOM_ITEMS = 1800;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Block inputs start at known values
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  separable_ar1_field_filter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Register shadow, as seen by the filter model. Values at reset.
  // ---------------------------------------------------------------------------
  logic [10:0]        row_len_q = 11'd1;
  logic [14:0]        rows_q    = 15'd1;
  logic signed [16:0] rho_q  [3] = '{17'sd0, 17'sd0, 17'sd0};
  logic [15:0]        gain_q [3] = '{16'd32768, 16'd32768, 16'd32768};

  // Filter state: axis-one history, raster position, row and plane stores
  logic signed [15:0] axis1_last   = '0;
  int unsigned        col_pos      = 0;
  int unsigned        row_pos      = 0;
  bit                 first_plane  = 1'b1;
  logic signed [15:0] line_mem  [MAX_ROW_LEN];
  logic signed [15:0] plane_mem [MAX_PLANE];

  // Samples waiting for the driver, and filter results waiting for the block
  in_item_t  noise_queue[$];
  out_item_t filtered_queue[$];

  int  samples_queued = 0;
  int  results_seen   = 0;
  int  errors         = 0;
  int  cycle_count    = 0;
  bit  idle_on        = 1'b1;
  bit  restart_due    = 1'b0;   // next queued sample must open a new field

  // One AR(1) stage: rho*prev + gain*x in Q6.27, round half up to Q4.12, clip.
  function automatic stage_res_t ar_stage(logic signed [16:0] rho, logic [15:0] gain,
                                          logic signed [15:0] prev, logic signed [15:0] x);
    longint     acc;
    stage_res_t r;
    acc = longint'(rho) * longint'(prev) + longint'(gain) * longint'(x);
    acc = (acc + 16384) >>> 15;   // arithmetic shift = floor
    r.clipped = 1'b0;
    if (acc > 32767) begin
      r.value   = 16'sh7FFF;
      r.clipped = 1'b1;
    end else if (acc < -32768) begin
      r.value   = 16'sh8000;
      r.clipped = 1'b1;
    end else begin
      r.value = acc[15:0];
    end
    return r;
  endfunction

  // Filters one accepted sample through all three axes and advances the raster.
  function automatic out_item_t filter_sample(in_item_t s);
    logic signed [15:0] y;
    stage_res_t         r;
    logic               sat;
    logic               ovf;
    int unsigned        len, rpp, c, pos;
    out_item_t          res;
    y   = s.noise_sample;
    sat = 1'b0;
    ovf = 1'b0;
    if (s.start_of_field) begin
      col_pos     = 0;
      row_pos     = 0;
      first_plane = 1'b1;
    end
    // zero acts as one, oversize clamps to the store depth
    len = (row_len_q == 0) ? 1 : ((row_len_q > MAX_ROW_LEN) ? MAX_ROW_LEN : row_len_q);
    rpp = (rows_q == 0) ? 1 : ((rows_q > ROWS_LIMIT) ? ROWS_LIMIT : rows_q);

    // axis one: first column passes through
    if (col_pos != 0) begin
      r   = ar_stage(rho_q[0], gain_q[0], axis1_last, y);
      y   = r.value;
      sat = sat | r.clipped;
    end
    axis1_last = y;

    // axis two: first row passes through
    c = (col_pos >= MAX_ROW_LEN) ? MAX_ROW_LEN - 1 : col_pos;
    if (row_pos != 0) begin
      r   = ar_stage(rho_q[1], gain_q[1], line_mem[c], y);
      y   = r.value;
      sat = sat | r.clipped;
    end
    line_mem[c] = y;

    // axis three: bypassed past the plane store, first plane passes through
    pos = row_pos * len + col_pos;
    if (pos >= MAX_PLANE) begin
      ovf = 1'b1;
    end else begin
      if (!first_plane) begin
        r   = ar_stage(rho_q[2], gain_q[2], plane_mem[pos], y);
        y   = r.value;
        sat = sat | r.clipped;
      end
      plane_mem[pos] = y;
    end

    col_pos++;
    if (col_pos >= len) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rpp) begin
        row_pos     = 0;
        first_plane = 1'b0;
      end
    end

    res.filtered_value = y;
    res.saturated      = sat;
    res.plane_overflow = ovf;
    return res;
  endfunction

  function automatic int draw_gap();
    return idle_on ? $urandom_range(IDLE_MAX, 0) : 0;
  endfunction

  function automatic logic signed [15:0] draw_noise();
    if ($urandom_range(7, 0) != 0) return 16'($urandom());
    case ($urandom_range(4, 0))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return -16'sd1;
      3:       return 16'sd0;
      default: return 16'sd1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: valid held with a stable payload until the transfer.
  // The model runs at the accepting edge.
  // ---------------------------------------------------------------------------
  int in_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready)
        filtered_queue.push_back(filter_sample(in_item));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (noise_queue.size() != 0) begin
          in_item  <= noise_queue.pop_front();
          in_valid <= 1'b1;
          in_gap   <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random stall after each transfer, field-wise compare.
  // ---------------------------------------------------------------------------
  int out_wait = 0;

  always @(posedge clk) begin : result_check
    out_item_t want;
    int        stall;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (filtered_queue.size() == 0) begin
          $display("%0t: result with none outstanding: expected nothing, got %p",
                   $time, out_item);
          errors++;
        end else begin
          want = filtered_queue.pop_front();
          if (out_item.filtered_value !== want.filtered_value) begin
            $display("%0t: filtered_value expected %0d, got %0d",
                     $time, want.filtered_value, out_item.filtered_value);
            errors++;
          end
          if (out_item.saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b, got %0b",
                     $time, want.saturated, out_item.saturated);
            errors++;
          end
          if (out_item.plane_overflow !== want.plane_overflow) begin
            $display("%0t: plane_overflow expected %0b, got %0b",
                     $time, want.plane_overflow, out_item.plane_overflow);
            errors++;
          end
        end
        stall = draw_gap();
        out_wait  <= stall;
        out_ready <= (stall == 0);
      end else if (out_wait != 0) begin
        out_wait  <= out_wait - 1;
        out_ready <= (out_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and sample queuing
  // ---------------------------------------------------------------------------
  task automatic reg_write(cfg_idx_t idx, logic [16:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ROW_LENGTH:     row_len_q = val[10:0];
      CFG_ROWS_PER_PLANE: rows_q    = val[14:0];
      CFG_RHO_AXIS1:      rho_q[0]  = val;
      CFG_RHO_AXIS2:      rho_q[1]  = val;
      CFG_RHO_AXIS3:      rho_q[2]  = val;
      CFG_GAIN_AXIS1:     gain_q[0] = val[15:0];
      CFG_GAIN_AXIS2:     gain_q[1] = val[15:0];
      CFG_GAIN_AXIS3:     gain_q[2] = val[15:0];
      default: ;
    endcase
  endtask

  task automatic reg_idle();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // New geometry: the following field restarts so no stale store entry is read
  task automatic set_size(logic [16:0] len, logic [16:0] rows);
    reg_write(CFG_ROW_LENGTH, len);
    reg_write(CFG_ROWS_PER_PLANE, rows);
    restart_due = 1'b1;
  endtask

  task automatic set_taps(logic [16:0] rho, logic [16:0] gain);
    reg_write(CFG_RHO_AXIS1, rho);
    reg_write(CFG_RHO_AXIS2, rho);
    reg_write(CFG_RHO_AXIS3, rho);
    reg_write(CFG_GAIN_AXIS1, gain);
    reg_write(CFG_GAIN_AXIS2, gain);
    reg_write(CFG_GAIN_AXIS3, gain);
  endtask

  // Per axis: bypass (rho 0, gain 1.0), an extreme pair, or random taps
  task automatic random_taps();
    for (int a = 0; a < 3; a++) begin
      logic [16:0] r;
      logic [16:0] g;
      case ($urandom_range(3, 0))
        0: begin
          r = '0;
          g = 17'd32768;
        end
        1: begin
          case ($urandom_range(3, 0))
            0:       r = 17'h10000;   // -2.0
            1:       r = 17'h0FFFF;   // just under 2.0
            2:       r = 17'h08000;   // +1.0
            default: r = 17'h18000;   // -1.0
          endcase
          case ($urandom_range(2, 0))
            0:       g = 17'd0;
            1:       g = 17'd32768;
            default: g = 17'd65535;
          endcase
        end
        default: begin
          r = 17'($urandom());
          g = 17'($urandom_range(32768, 0));
        end
      endcase
      reg_write(cfg_idx_t'(CFG_RHO_AXIS1 + a), r);
      reg_write(cfg_idx_t'(CFG_GAIN_AXIS1 + a), g);
    end
  endtask

  task automatic push_one(logic signed [15:0] v, bit sof);
    in_item_t s;
    s.noise_sample   = v;
    s.start_of_field = sof | restart_due;
    restart_due      = 1'b0;
    noise_queue.push_back(s);
    samples_queued++;
  endtask

  // mixed: occasional start_of_field inside the run
  task automatic push_samples(int n, bit mixed);
    for (int i = 0; i < n; i++)
      push_one(draw_noise(), mixed && ($urandom_range(49, 0) == 0));
  endtask

  // Wait for every queued sample's result, then let the pipeline settle
  task automatic drain();
    while (results_seen < samples_queued) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int random_count;
    int n;
    phase        = 0;
    random_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (1x1 plane, all axes bypass): first sample without
    // start_of_field relies on the reset position.
    push_one(16'sh7FFF, 1'b0);
    push_one(16'sh8000, 1'b1);
    push_one(16'sd0, 1'b0);
    push_one(-16'sd1, 1'b0);
    push_one(16'sd1, 1'b0);
    drain();

    // Largest rho and gain on 2x2
    set_size(17'd2, 17'd2);
    set_taps(17'h0FFFF, 17'd65535);
    reg_idle();
    push_one(16'sh7FFF, 1'b0);
    push_one(16'sh7FFF, 1'b0);
    push_one(16'sh8000, 1'b0);
    push_one(16'sh8000, 1'b0);
    push_one(16'sh7FFF, 1'b0);
    push_one(16'sh8000, 1'b0);
    push_one(16'sd1, 1'b0);
    push_one(-16'sd1, 1'b0);
    drain();

    // rho -2.0 with zero gain, 3x1: first element still passes unchanged
    set_size(17'd3, 17'd1);
    set_taps(17'h10000, 17'd0);
    reg_idle();
    push_one(16'sh7FFF, 1'b0);
    push_one(16'sh8000, 1'b0);
    push_one(16'sd100, 1'b0);
    push_one(16'sh7FFF, 1'b0);
    push_one(16'sh8000, 1'b0);
    push_one(16'sd0, 1'b0);
    drain();

    // Shrink mid-field: at row 1, column 5 of an 8x4 field switch to 3x1.
    // Column and row both wrap on the next step; all reads hit written entries.
    random_taps();
    set_size(17'd8, 17'd4);
    reg_idle();
    push_samples(13, 1'b0);
    drain();
    reg_write(CFG_ROW_LENGTH, 17'd3);
    reg_write(CFG_ROWS_PER_PLANE, 17'd1);
    reg_idle();
    push_samples(20, 1'b0);
    drain();

    // Plane store overflow: line store columns 0..7 written first, then a
    // zero-length column field reaches row 17, then rows grow to the clamped
    // 1024 width without a restart. Positions land past the plane store.
    random_taps();
    set_size(17'd8, 17'd2);
    reg_idle();
    push_samples(8, 1'b0);
    drain();
    set_size(17'd0, 17'd32767);
    reg_idle();
    push_samples(17, 1'b0);
    drain();
    reg_write(CFG_ROW_LENGTH, 17'd2047);
    reg_idle();
    push_samples(8, 1'b0);
    drain();

    // Random phases; the first one opens a fresh field, one of them uses
    // the full 1024-wide row
    while (random_count < RANDOM_ITEMS) begin
      random_taps();
      if (phase == 2) begin
        set_size(17'd1024, 17'd2);
      end else if (phase == 0 || $urandom_range(2, 0) != 0) begin
        set_size(($urandom_range(9, 0) == 0) ? 17'd0 :
                 ($urandom_range(19, 0) == 0) ? 17'd2047 : 17'($urandom_range(9, 1)),
                 ($urandom_range(9, 0) == 0) ? 17'd0 :
                 ($urandom_range(9, 0) == 0) ? 17'd32767 : 17'($urandom_range(5, 1)));
      end
      reg_idle();
      idle_on = ($urandom_range(3, 0) != 0);
      n = (phase == 2) ? 1050 : $urandom_range(120, 40);
      push_samples(n, 1'b1);
      random_count += n;
      phase++;
      drain();
    end

    repeat (20) @(posedge clk);
    if (filtered_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, filtered_queue.size());
      errors++;
    end
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/saff_pkg.sv
hdl/saff_stage.sv
hdl/separable_ar1_field_filter.sv
bench/tb.sv
